[rtl/core/ccwc_pkg.sv]
// ccwc_pkg: shared constants and control/status types for the coin change way counter
// used by ccwc_ctrl, ccwc_dp and the top level; depends on nothing
package ccwc_pkg;

    localparam int unsigned MAX_AMOUNT  = 1023;
    localparam int unsigned TABLE_DEPTH = MAX_AMOUNT + 1;
    localparam int unsigned ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int unsigned COUNT_W     = 32;
    localparam int unsigned ENTRY_W     = COUNT_W + 1;

    typedef logic [ADDR_W-1:0]  addr_t;
    typedef logic [COUNT_W-1:0] count_t;

    // commands from controller to datapath
    typedef struct packed {
        logic load_item;
        logic sweep;
        logic clear;
        logic load_out;
    } ccwc_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic in_skip;
        logic in_last;
        logic r_at_max;
        logic last_item;
        logic out_free;
    } ccwc_sts_t;

endpackage

[rtl/core/coin_change_way_counter.sv]
// coin_change_way_counter: one coin per transaction; each coin c sweeps the amounts c to MAX_AMOUNT
// with one table read-modify-write per amount through the single write port of the way table
// a coin of zero or above MAX_AMOUNT skips the sweep; a last coin is followed by the result read
// then a clearing pass over all MAX_AMOUNT + 1 entries (1024) restores the table before the next set
// after rst_n the same clearing pass runs with in_stall high; control state resets at once
// depends on ccwc_pkg, ccwc_ctrl, ccwc_dp, ccwc_ram
module coin_change_way_counter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [9:0]  coin_value,
    input  logic        last_coin,
    input  logic [9:0]  target_amount,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] way_count,
    output logic        saturated
);
    import ccwc_pkg::*;

    ccwc_cmd_t cmd;
    ccwc_sts_t sts;

    // sequencer: clear pass, sweep of one coin, result read and hand-off
    ccwc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // way table with a two-stage read/add pipe; the output register lets the
    // next set start while a result transaction is still stalled
    ccwc_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .coin_value    (coin_value),
        .last_coin     (last_coin),
        .target_amount (target_amount),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .way_count     (way_count),
        .saturated     (saturated),
        .cmd           (cmd),
        .sts           (sts)
    );

endmodule

[rtl/core/ccwc_ram.sv]
// ccwc_ram: generic memory, one write port and two registered read ports
// no dependencies
module ccwc_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] ra_addr,
    output logic [WIDTH-1:0]         ra_data,
    input  logic [$clog2(DEPTH)-1:0] rb_addr,
    output logic [WIDTH-1:0]         rb_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        ra_data <= mem[ra_addr];
        rb_data <= mem[rb_addr];
    end

endmodule

[rtl/core/ccwc_ctrl.sv]
// ccwc_ctrl: sequencing state machine (clear pass, coin sweep, result read)
// depends on ccwc_pkg
module ccwc_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  ccwc_pkg::ccwc_sts_t sts,
    output ccwc_pkg::ccwc_cmd_t cmd
);
    import ccwc_pkg::*;

    typedef enum logic [5:0] {
        ST_CLEAR  = 6'b000001,
        ST_IDLE   = 6'b000010,
        ST_SWEEP  = 6'b000100,
        ST_DRAIN  = 6'b001000,
        ST_READ   = 6'b010000,
        ST_RESULT = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (sts.r_at_max)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    if (!sts.in_skip)
                    begin
                        state_next = ST_SWEEP;
                    end
                    else if (sts.in_last)
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_SWEEP:
            begin
                cmd.sweep = 1'b1;
                if (sts.r_at_max)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = sts.last_item ? ST_READ : ST_IDLE;
            end
            ST_READ:
            begin
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_CLEAR;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

[rtl/core/ccwc_dp.sv]
// ccwc_dp: way table memory, amount counter, add/saturate pipe with forwarding, output register
// depends on ccwc_pkg and ccwc_ram
module ccwc_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [9:0]          coin_value,
    input  logic                last_coin,
    input  logic [9:0]          target_amount,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [31:0]         way_count,
    output logic                saturated,
    input  ccwc_pkg::ccwc_cmd_t cmd,
    output ccwc_pkg::ccwc_sts_t sts
);
    import ccwc_pkg::*;

    addr_t  r_reg, r_next;
    addr_t  coin_reg;
    addr_t  tgt_reg;
    logic   tgt_ok_reg;
    logic   last_reg;
    logic   p_valid_reg;
    addr_t  p_addr_reg;
    logic   fwd_reg;
    logic [ENTRY_W-1:0] prev_w_reg;
    logic   out_valid_reg, out_valid_next;
    count_t out_count_reg;
    logic   out_sat_reg;

    addr_t  ra_addr, rb_addr, waddr;
    logic   we;
    logic [ENTRY_W-1:0] wdata, ra_data, rb_data, b_entry, sum_entry;
    logic [COUNT_W:0]   sum;
    logic   coin_big;

    assign coin_big = ({22'd0, coin_value} > 32'(MAX_AMOUNT));

    assign sts.in_skip   = (coin_value == 10'd0) || coin_big;
    assign sts.in_last   = last_coin;
    assign sts.r_at_max  = (r_reg == addr_t'(MAX_AMOUNT));
    assign sts.last_item = last_reg;
    assign sts.out_free  = !out_valid_reg || !out_stall;

    // read ports: entry r and entry r - coin during a sweep, target otherwise
    assign ra_addr = cmd.sweep ? r_reg : tgt_reg;
    assign rb_addr = r_reg - coin_reg;

    // sum stage, with the previous write forwarded when it is the r - coin entry
    assign b_entry = fwd_reg ? prev_w_reg : rb_data;
    assign sum     = {1'b0, ra_data[COUNT_W-1:0]} + {1'b0, b_entry[COUNT_W-1:0]};
    assign sum_entry = sum[COUNT_W]
                     ? {1'b1, {COUNT_W{1'b1}}}
                     : {ra_data[COUNT_W] | b_entry[COUNT_W], sum[COUNT_W-1:0]};

    always_comb
    begin
        we    = 1'b0;
        waddr = r_reg;
        wdata = '0;
        priority if (p_valid_reg)
        begin
            we    = 1'b1;
            waddr = p_addr_reg;
            wdata = sum_entry;
        end
        else if (cmd.clear)
        begin
            we    = 1'b1;
            waddr = r_reg;
            wdata = (r_reg == '0) ? ENTRY_W'(1) : '0;
        end
        else
        begin
            we    = 1'b0;
            waddr = r_reg;
            wdata = '0;
        end
    end

    ccwc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .ra_addr (ra_addr),
        .ra_data (ra_data),
        .rb_addr (rb_addr),
        .rb_data (rb_data)
    );

    always_comb
    begin
        r_next = r_reg;
        priority if (cmd.load_item)
        begin
            r_next = addr_t'(coin_value);
        end
        else if (cmd.load_out)
        begin
            r_next = '0;
        end
        else if (cmd.sweep || cmd.clear)
        begin
            r_next = sts.r_at_max ? '0 : r_reg + addr_t'(1);
        end
        else
        begin
            r_next = r_reg;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_reg         <= '0;
            p_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            last_reg      <= 1'b0;
        end
        else
        begin
            r_reg         <= r_next;
            p_valid_reg   <= cmd.sweep;
            out_valid_reg <= out_valid_next;
            if (cmd.load_item)
            begin
                last_reg <= last_coin;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        p_addr_reg <= r_reg;
        fwd_reg    <= p_valid_reg && (rb_addr == p_addr_reg);
        if (we)
        begin
            prev_w_reg <= wdata;
        end
        if (cmd.load_item)
        begin
            coin_reg   <= addr_t'(coin_value);
            tgt_reg    <= addr_t'(target_amount);
            tgt_ok_reg <= ({22'd0, target_amount} <= 32'(MAX_AMOUNT));
        end
        if (cmd.load_out)
        begin
            out_count_reg <= tgt_ok_reg ? ra_data[COUNT_W-1:0] : '0;
            out_sat_reg   <= tgt_ok_reg & ra_data[COUNT_W];
        end
    end

    assign out_valid = out_valid_reg;
    assign way_count = out_count_reg;
    assign saturated = out_sat_reg;

endmodule

[rtl/core/ccwc_chk.sv]
// ccwc_chk: port-level checks for coin_change_way_counter, bound to the top level
// depends on nothing but the top-level port list
module ccwc_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        last_coin,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] way_count,
    input logic        saturated
);

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(way_count) && $stable(saturated))
        else $error("result changed while stalled");

    // a saturated count is always pinned at the maximum
    a_sat_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |-> way_count == 32'hFFFF_FFFF)
        else $error("saturated flag without maximum count");

    // a new result starts the clearing pass, so input is held off
    a_rose_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> in_stall)
        else $error("input taken while a new result appeared");

    // an intermediate coin never yields a result
    a_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !last_coin && !out_valid |=> !out_valid)
        else $error("result after a coin that is not last");

endmodule

bind coin_change_way_counter ccwc_chk u_ccwc_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .last_coin (last_coin),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .way_count (way_count),
    .saturated (saturated)
);
